[rtl/tep_pkg.sv]
// ----------------------------------------------------------------------------
// tep_pkg
// shared types, constants and helper functions for the tree entry parser
// ----------------------------------------------------------------------------
package tep_pkg;

    // number of binary hash bytes that close one entry
    localparam int HASH_BYTES = 20;
    localparam int HASH_IDX_W = $clog2(HASH_BYTES);

    localparam int MODE_LEN_W = 3;
    localparam logic [MODE_LEN_W-1:0] BLOB_MODE_LEN = 3'd6;
    localparam logic [MODE_LEN_W-1:0] MODE_LEN_MAX  = 3'd7;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] NUL_CHAR   = 8'h00;
    localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'
    localparam logic [7:0] ALPHA_BASE = 8'h57;  // 'a' minus ten
    localparam logic [3:0] NIB_TEN    = 4'd10;

    localparam logic KIND_NAME  = 1'b0;
    localparam logic KIND_HASH  = 1'b1;
    localparam logic TYPE_BLOB  = 1'b0;
    localparam logic TYPE_TREE  = 1'b1;

    typedef enum logic [1:0] {
        PH_MODE = 2'd0,
        PH_NAME = 2'd1,
        PH_HASH = 2'd2
    } phase_t;

    typedef struct packed {
        logic       last;
        logic       start;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic       entry_last;
        logic       entry_type;
        logic [7:0] low_char;
        logic [7:0] high_char;
        logic       kind;
    } result_t;

    // lower-case hex character of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < NIB_TEN)
            return DIGIT_BASE + wide;
        else
            return ALPHA_BASE + wide;
    endfunction

    // expected character at each place of the blob mode "100644"
    function automatic logic [7:0] blob_mode_char(input logic [MODE_LEN_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h31;
            3'd1:    c = 8'h30;
            3'd2:    c = 8'h30;
            3'd3:    c = 8'h36;
            3'd4:    c = 8'h34;
            3'd5:    c = 8'h34;
            default: c = NUL_CHAR;
        endcase
        return c;
    endfunction

endpackage

[rtl/tep_in_reg.sv]
// ----------------------------------------------------------------------------
// tep_in_reg
// input register stage: holds one body byte until the parser takes it
// ----------------------------------------------------------------------------
module tep_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tep_pkg::in_item_t in_item,
    input  logic              take,
    output logic              held_valid,
    output tep_pkg::in_item_t held_item
);

    logic              valid_reg;
    logic              valid_next;
    tep_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

endmodule

[rtl/tep_parser.sv]
// ----------------------------------------------------------------------------
// tep_parser
// entry phase tracking and per-byte result decode
// ----------------------------------------------------------------------------
module tep_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tep_pkg::in_item_t item,
    output logic              res_valid,
    output tep_pkg::result_t  res
);

    tep_pkg::phase_t                    phase_reg,     phase_next;
    logic [tep_pkg::MODE_LEN_W-1:0]     mode_len_reg,  mode_len_next;
    logic                               mode_ok_reg,   mode_ok_next;
    logic [tep_pkg::HASH_IDX_W-1:0]     hash_idx_reg,  hash_idx_next;
    logic                               type_reg,      type_next;

    // state as seen after an optional restart on start of body
    tep_pkg::phase_t                    ph_eff;
    logic [tep_pkg::MODE_LEN_W-1:0]     mode_len_eff;
    logic                               mode_ok_eff;
    logic [tep_pkg::HASH_IDX_W-1:0]     hash_idx_eff;
    logic                               hash_fin;

    assign ph_eff       = item.start ? tep_pkg::PH_MODE : phase_reg;
    assign mode_len_eff = item.start ? '0 : mode_len_reg;
    assign mode_ok_eff  = item.start ? 1'b1 : mode_ok_reg;
    assign hash_idx_eff = item.start ? '0 : hash_idx_reg;
    assign hash_fin     = {1'b0, hash_idx_eff} >= (tep_pkg::HASH_IDX_W + 1)'(tep_pkg::HASH_BYTES - 1);

    // next state
    always_comb
    begin
        phase_next    = ph_eff;
        mode_len_next = mode_len_eff;
        mode_ok_next  = mode_ok_eff;
        hash_idx_next = hash_idx_eff;
        type_next     = type_reg;
        case (ph_eff)
            tep_pkg::PH_NAME:
            begin
                if (item.data == tep_pkg::NUL_CHAR)
                begin
                    phase_next    = tep_pkg::PH_HASH;
                    hash_idx_next = '0;
                end
            end
            tep_pkg::PH_HASH:
            begin
                if (hash_fin)
                begin
                    phase_next    = tep_pkg::PH_MODE;
                    mode_len_next = '0;
                    mode_ok_next  = 1'b1;
                    hash_idx_next = '0;
                end
                else
                    hash_idx_next = hash_idx_eff + 1'b1;
            end
            default:
            begin
                // mode phase, the unused code behaves the same
                if (item.data == tep_pkg::SPACE_CHAR)
                begin
                    type_next  = (mode_ok_eff && mode_len_eff == tep_pkg::BLOB_MODE_LEN)
                               ? tep_pkg::TYPE_BLOB : tep_pkg::TYPE_TREE;
                    phase_next = tep_pkg::PH_NAME;
                end
                else
                begin
                    if (mode_len_eff < tep_pkg::BLOB_MODE_LEN)
                    begin
                        if (item.data != tep_pkg::blob_mode_char(mode_len_eff))
                            mode_ok_next = 1'b0;
                    end
                    else
                        mode_ok_next = 1'b0;
                    if (mode_len_eff < tep_pkg::MODE_LEN_MAX)
                        mode_len_next = mode_len_eff + 1'b1;
                end
            end
        endcase
        if (item.last)
        begin
            phase_next    = tep_pkg::PH_MODE;
            mode_len_next = '0;
            mode_ok_next  = 1'b1;
            hash_idx_next = '0;
        end
    end

    // result decode
    always_comb
    begin
        res_valid      = 1'b0;
        res.kind       = tep_pkg::KIND_NAME;
        res.high_char  = item.data;
        res.low_char   = tep_pkg::NUL_CHAR;
        res.entry_type = type_reg;
        res.entry_last = 1'b0;
        case (ph_eff)
            tep_pkg::PH_NAME:
                res_valid = (item.data != tep_pkg::NUL_CHAR);
            tep_pkg::PH_HASH:
            begin
                res_valid      = 1'b1;
                res.kind       = tep_pkg::KIND_HASH;
                res.high_char  = tep_pkg::hex_char(item.data[7:4]);
                res.low_char   = tep_pkg::hex_char(item.data[3:0]);
                res.entry_last = hash_fin;
            end
            default:
                res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tep_pkg::PH_MODE;
            mode_len_reg <= '0;
            mode_ok_reg  <= 1'b1;
            hash_idx_reg <= '0;
            type_reg     <= tep_pkg::TYPE_BLOB;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            mode_len_reg <= mode_len_next;
            mode_ok_reg  <= mode_ok_next;
            hash_idx_reg <= hash_idx_next;
            type_reg     <= type_next;
        end
    end

`ifndef ASSERT_OFF
    // the hash counter only moves inside the hash phase
    a_hash_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != tep_pkg::PH_HASH) |-> (hash_idx_reg == '0))
        else $error("hash index nonzero outside hash phase");
`endif

endmodule

[rtl/tree_entry_stream_parser.sv]
// ----------------------------------------------------------------------------
// tree_entry_stream_parser
// byte-wise parser for tree object bodies: names pass through, hashes as hex
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                      | tuser                  | tlast
//  ---------+-----+----------------------------+------------------------+------------
//  s_axis   | in  | [7:0] data_byte            | [0] start_of_body      | end_of_body
//  m_axis   | out | [7:0] high_char [15:8] low | [0] kind [1] entry_type| entry_last
//
//  one body byte per cycle sustained while the output does not stall; a byte waits in
//  the input register and its result is written into the output register as it leaves
//  mode, space and terminator bytes are consumed without any output transfer
//  reset (rst_n low, async) empties both registers and returns to mode phase
//  a stalled output holds its transfer and the byte in the input register;
//  s_axis_tready drops once that register is full behind the stalled output
//
module tree_entry_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_of_body
    input  logic        s_axis_tlast,   // end_of_body
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] high_char, [15:8] low_char
    output logic [1:0]  m_axis_tuser,   // [0] kind, [1] entry_type
    output logic        m_axis_tlast    // entry_last
);

    tep_pkg::in_item_t in_item;
    tep_pkg::in_item_t held_item;
    logic              held_valid;
    logic              advance;
    logic              res_valid;
    tep_pkg::result_t  res;

    logic              out_valid_reg;
    logic              out_valid_next;
    tep_pkg::result_t  out_reg;

    assign in_item.data  = s_axis_tdata;
    assign in_item.start = s_axis_tuser;
    assign in_item.last  = s_axis_tlast;

    // held byte moves on whenever the output register is free or being emptied
    assign advance = held_valid && (!out_valid_reg || m_axis_tready);

    tep_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res_valid)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.low_char, out_reg.high_char};
    assign m_axis_tuser  = {out_reg.entry_type, out_reg.kind};
    assign m_axis_tlast  = out_reg.entry_last;

`ifndef ASSERT_OFF
    // entry end is only flagged on a hash transfer
    a_last_on_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[0] == tep_pkg::KIND_HASH))
        else $error("entry_last on a name transfer");

    // name transfers carry a zero low character
    a_name_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == tep_pkg::KIND_NAME)
        |-> (m_axis_tdata[15:8] == tep_pkg::NUL_CHAR))
        else $error("name transfer with nonzero low character");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");
`endif

endmodule

[sim/entry_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entry_check_pkg
// expected-output tracker for the tree entry parser: follows the parse of
// every accepted body byte and checks output transfers in order
// ----------------------------------------------------------------------------
package entry_check_pkg;

    import tep_pkg::*;

    class hex_entry_tracker;

        phase_t                phase;
        logic [MODE_LEN_W-1:0] mode_len;
        logic                  mode_ok;
        logic [HASH_IDX_W-1:0] hash_idx;
        logic                  entry_kind;
        result_t               awaited_chars[$];
        int unsigned           mismatch_count;

        function new();
            restart_entry();
            entry_kind = TYPE_BLOB;
            mismatch_count = 0;
        endfunction

        // entry type survives a restart, the counters do not
        function void restart_entry();
            phase = PH_MODE;
            mode_len = '0;
            mode_ok = 1'b1;
            hash_idx = '0;
        endfunction

        function logic [7:0] nibble_char(input logic [3:0] nib);
            string hex_digits;
            hex_digits = "0123456789abcdef";
            return hex_digits[nib];
        endfunction

        // one accepted input transfer
        function void note_body_byte(input in_item_t item);
            result_t char_out;
            string   blob_text;
            logic    closing;
            blob_text = "100644";
            char_out = '0;
            if (item.start)
                restart_entry();
            case (phase)
                PH_NAME:
                begin
                    if (item.data == NUL_CHAR)
                    begin
                        phase = PH_HASH;
                        hash_idx = '0;
                    end
                    else
                    begin
                        char_out.kind = KIND_NAME;
                        char_out.high_char = item.data;
                        char_out.low_char = NUL_CHAR;
                        char_out.entry_type = entry_kind;
                        char_out.entry_last = 1'b0;
                        awaited_chars.insert(awaited_chars.size(), char_out);
                    end
                end
                PH_HASH:
                begin
                    closing = (int'(hash_idx) + 1 >= HASH_BYTES);
                    char_out.kind = KIND_HASH;
                    char_out.high_char = nibble_char(item.data[7:4]);
                    char_out.low_char = nibble_char(item.data[3:0]);
                    char_out.entry_type = entry_kind;
                    char_out.entry_last = closing;
                    awaited_chars.insert(awaited_chars.size(), char_out);
                    if (closing)
                        restart_entry();
                    else
                        hash_idx = hash_idx + 1'b1;
                end
                default:
                begin
                    if (item.data == SPACE_CHAR)
                    begin
                        entry_kind = (mode_ok && mode_len == BLOB_MODE_LEN) ? TYPE_BLOB
                                                                            : TYPE_TREE;
                        phase = PH_NAME;
                    end
                    else
                    begin
                        if (mode_len < BLOB_MODE_LEN)
                        begin
                            if (item.data != blob_text[mode_len])
                                mode_ok = 1'b0;
                        end
                        else
                            mode_ok = 1'b0;
                        if (mode_len < MODE_LEN_MAX)
                            mode_len = mode_len + 1'b1;
                    end
                end
            endcase
            if (item.last)
                restart_entry();
        endfunction

        function void compare_field(input string field, input logic [7:0] want,
                                    input logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                         $time, field, want, got);
                mismatch_count++;
            end
        endfunction

        // one accepted output transfer
        function void check_char_transfer(input result_t got);
            result_t want;
            if (awaited_chars.size() == 0)
            begin
                $display("%0t: unexpected output transfer, expected none, actual %h",
                         $time, got);
                mismatch_count++;
            end
            else
            begin
                want = awaited_chars.pop_front();
                compare_field("kind", 8'(want.kind), 8'(got.kind));
                compare_field("high_char", want.high_char, got.high_char);
                compare_field("low_char", want.low_char, got.low_char);
                compare_field("entry_type", 8'(want.entry_type), 8'(got.entry_type));
                compare_field("entry_last", 8'(want.entry_last), 8'(got.entry_last));
            end
        endfunction

    endclass

endpackage

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives tree object bodies into the entry parser: a few hand-built bodies
// for the corner cases, then random bodies of mostly well-formed entries,
// with bursty input, a stalling output and one long output hold-off
// ----------------------------------------------------------------------------
module testbench;

    import tep_pkg::*;
    import entry_check_pkg::*;

    localparam int RANDOM_BYTES   = 1700;
    localparam int SQUEEZE_CYCLES = 200;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] start_of_body
    logic        s_axis_tlast;   // end_of_body
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] high_char, [15:8] low_char
    logic [1:0]  m_axis_tuser;   // [0] kind, [1] entry_type
    logic        m_axis_tlast;   // entry_last

    hex_entry_tracker tracker;
    in_item_t         body_q[$];
    int               burst_left = 0;
    int               bytes_sent = 0;
    int               idle_cycles = 0;
    bit               squeeze_req = 1'b0;

    tree_entry_stream_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // both sides sampled at the edge, before any of this edge's updates land
    always @(posedge clk)
    begin : transfer_monitor
        in_item_t taken;
        result_t  seen;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.data = s_axis_tdata;
                taken.start = s_axis_tuser;
                taken.last = s_axis_tlast;
                tracker.note_body_byte(taken);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.high_char = m_axis_tdata[7:0];
                seen.low_char = m_axis_tdata[15:8];
                seen.kind = m_axis_tuser[0];
                seen.entry_type = m_axis_tuser[1];
                seen.entry_last = m_axis_tlast;
                tracker.check_char_transfer(seen);
            end
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // output side: stretches of always-ready, random stalls and a fixed
    // rhythm, plus one long hold-off once the random bodies start
    initial
    begin : receiver_pattern
        int style;
        int stretch;
        int step;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_req)
            begin
                // input keeps offering; both registers fill and tready drops
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_req = 1'b0;
            end
            style = $urandom_range(0, 3);
            stretch = $urandom_range(8, 60);
            for (step = 0; step < stretch; step++)
            begin
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= (step % 3 != 2);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // one input transfer; valid stays high inside a burst
    task automatic send_body_byte(input in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= item.data;
        s_axis_tuser <= item.start;
        s_axis_tlast <= item.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic flush_body();
        foreach (body_q[i])
            send_body_byte(body_q[i]);
        body_q.delete();
    endtask

    function automatic void put_byte(input logic [7:0] b);
        in_item_t item;
        item.data = b;
        item.start = 1'b0;
        item.last = 1'b0;
        body_q.insert(body_q.size(), item);
    endfunction

    function automatic void put_text(input string text);
        for (int i = 0; i < text.len(); i++)
            put_byte(text[i]);
    endfunction

    // one entry: a mode (often the blob mode, sometimes near misses or junk),
    // space, a nonzero name, terminator and a full hash
    function automatic void put_entry();
        string mode_text;
        int    pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3, 7: mode_text = "100644";
            4:             mode_text = "40000";
            5:             mode_text = "120000";
            6:             mode_text = "160000";
            8:
            begin
                if ($urandom_range(0, 1) != 0)
                    mode_text = "10064";
                else
                    mode_text = "1006444";
            end
            default:       mode_text = "";
        endcase
        put_text(mode_text);
        if (pick == 7)
            body_q[body_q.size() - 1 - $urandom_range(0, 5)].data = 8'h30 + 8'($urandom_range(0, 9));
        if (pick == 9)
        begin
            repeat ($urandom_range(0, 9))
                put_byte(($urandom_range(0, 1) != 0) ? 8'h30 + 8'($urandom_range(0, 9))
                                                     : 8'($urandom_range(0, 255)) | 8'h01);
        end
        put_byte(SPACE_CHAR);
        repeat ($urandom_range(1, 12))
            put_byte(8'($urandom_range(1, 255)));
        put_byte(NUL_CHAR);
        repeat (HASH_BYTES)
            put_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_body();
        int cut;
        repeat ($urandom_range(1, 4))
            put_entry();
        // sometimes cut an entry short so the end flag lands mid-entry
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, body_q.size());
            while (body_q.size() > cut)
                body_q.delete(body_q.size() - 1);
        end
        if ($urandom_range(0, 19) == 0)
            body_q[$urandom_range(0, body_q.size() - 1)].start = 1'b1;
        if ($urandom_range(0, 7) != 0)
            body_q[0].start = 1'b1;
        if ($urandom_range(0, 7) != 0)
            body_q[body_q.size() - 1].last = 1'b1;
    endfunction

    // unstructured bytes, heavy on spaces and terminators, random flags
    function automatic void build_noise();
        in_item_t item;
        repeat ($urandom_range(1, 16))
        begin
            case ($urandom_range(0, 3))
                0:       item.data = SPACE_CHAR;
                1:       item.data = NUL_CHAR;
                default: item.data = 8'($urandom_range(0, 255));
            endcase
            item.start = ($urandom_range(0, 7) == 0);
            item.last = ($urandom_range(0, 7) == 0);
            body_q.insert(body_q.size(), item);
        end
    endfunction

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // blob entry, name with extreme bytes, end flag inside the hash
        put_text("100644");
        put_byte(SPACE_CHAR);
        put_byte(8'h01);
        put_byte(8'hFF);
        put_byte(8'h7F);
        put_byte(NUL_CHAR);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h9A);
        put_byte(8'hA9);
        body_q[0].start = 1'b1;
        body_q[body_q.size() - 1].last = 1'b1;
        flush_body();

        // mode longer than seven bytes saturates and gives a tree
        put_text("10064444");
        put_byte(SPACE_CHAR);
        put_byte(8'h4C);
        body_q[0].start = 1'b1;
        body_q[body_q.size() - 1].last = 1'b1;
        flush_body();

        // start flag inside a mode, landing on a space: empty mode
        put_text("10");
        put_byte(SPACE_CHAR);
        put_byte(8'h65);
        body_q[0].start = 1'b1;
        body_q[2].start = 1'b1;
        body_q[body_q.size() - 1].last = 1'b1;
        flush_body();

        // single byte carrying both start and end
        put_byte(8'h78);
        body_q[0].start = 1'b1;
        body_q[0].last = 1'b1;
        flush_body();

        // random bodies
        squeeze_req = 1'b1;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                build_noise();
            else
                build_body();
            flush_body();
        end
        s_axis_tvalid <= 1'b0;

        while (tracker.awaited_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[tree_entry_stream_parser.f]
rtl/tep_pkg.sv
rtl/tep_in_reg.sv
rtl/tep_parser.sv
rtl/tree_entry_stream_parser.sv
sim/entry_check_pkg.sv
sim/testbench.sv
